// ----- sv/raster_fill_copy_blend_scale_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the raster pixel engine
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RASTER_FILL_COPY_BLEND_SCALE_ASSERT_SVH
`define RASTER_FILL_COPY_BLEND_SCALE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define RFCBS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent
`define RFCBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rfcbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rfcbs_pkg
// Types, register codes, reset values and the blend divide helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rfcbs_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd4;

	// Field widths
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 10;
	localparam int STRIDE_W = 13;
	localparam int INDEX_W  = 22;
	localparam int DROW_W   = HEIGHT_W + 1;
	localparam int DCOL_W   = WIDTH_W + 1;

	// Reset values
	localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd16;
	localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 10'd16;
	localparam logic [15:0]         RST_FILL   = 16'hFAAA;
	localparam logic [STRIDE_W-1:0] RST_STRIDE = 13'd800;

	// Queue between front and back
	localparam int RFCBS_QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		MODE_FILL  = 2'd0,
		MODE_COPY  = 2'd1,
		MODE_ALPHA = 2'd2,
		MODE_SCALE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_PASS   = 2'd0,
		OP_BLEND  = 2'd1,
		OP_DOUBLE = 2'd2
	} op_t;

	typedef struct packed {
		logic [31:0] src_pixel;
		logic [15:0] dest_pixel;
	} pix_t;

	typedef struct packed {
		logic [INDEX_W-1:0] dest_index;
		logic [15:0]        pixel_out;
		logic               last;
	} wr_t;

	// Classified work item handed from front to back
	typedef struct packed {
		op_t               op;
		logic [31:0]       src;
		logic [15:0]       dst;
		logic [DROW_W-1:0] drow;
		logic [DCOL_W-1:0] dcol;
		logic              last;
	} qent_t;

	// Floor of x / 255 for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] y;
		logic [16:0] t;
		y = {1'b0, x} + 17'd1;
		t = y + (y >> 8);
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

// ----- sv/rfcbs_front.sv -----
// ----------------------------------------------------------------------------
// rfcbs_front
// Register file, raster counters and item classification into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "raster_fill_copy_blend_scale_assert.svh"

module rfcbs_front import rfcbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  pix_valid,
	output logic                       pix_stall,
	input  wire pix_t                  pix_data,
	input  wire logic                  full,
	output logic                       push,
	output qent_t                      push_entry,
	output logic [STRIDE_W-1:0]        dest_stride
);

	mode_t               mode_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [15:0]         fill_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [WIDTH_W-1:0]  col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic                phase_q;

	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic                col_end;
	logic                row_end;
	logic                scale;
	logic                fin;
	logic                restart;

	// Accept whenever the queue has room
	assign pix_stall   = full;
	assign push        = pix_valid && !full;
	assign dest_stride = stride_q;

	// Treat a zero size as one
	assign w_eff   = (width_q == '0) ? WIDTH_W'(1) : width_q;
	assign h_eff   = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	assign col_end = ({1'b0, col_q} + (WIDTH_W+1)'(1)) >= {1'b0, w_eff};
	assign row_end = ({1'b0, row_q} + (HEIGHT_W+1)'(1)) >= {1'b0, h_eff};
	assign scale   = (mode_q == MODE_SCALE);
	assign fin     = col_end && row_end && (!scale || phase_q);

	assign restart = cfg_we && (cfg_index == REG_MODE || cfg_index == REG_WIDTH ||
		cfg_index == REG_HEIGHT);

	// Classify the item and place it in destination coordinates
	always_comb begin
		push_entry.src  = pix_data.src_pixel;
		push_entry.dst  = pix_data.dest_pixel;
		push_entry.last = fin;
		push_entry.drow = scale ? {row_q, phase_q} : {1'b0, row_q};
		push_entry.dcol = scale ? {col_q, 1'b0} : {1'b0, col_q};
		unique case (mode_q)
			MODE_FILL: begin
				push_entry.op  = OP_PASS;
				push_entry.src = {16'h0000, fill_q};
			end
			MODE_COPY:  push_entry.op = OP_PASS;
			MODE_ALPHA: push_entry.op = OP_BLEND;
			MODE_SCALE: push_entry.op = OP_DOUBLE;
			default:    push_entry.op = OP_PASS;
		endcase
	end

	// Take register writes; advance counters per accepted beat unless a register is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FILL;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			fill_q   <= RST_FILL;
			stride_q <= RST_STRIDE;
			col_q    <= '0;
			row_q    <= '0;
			phase_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				REG_FILL:   fill_q   <= cfg_data[15:0];
				REG_STRIDE: stride_q <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
			if (restart) begin
				col_q   <= '0;
				row_q   <= '0;
				phase_q <= 1'b0;
			end
		end else if (push) begin
			if (col_end) begin
				col_q <= '0;
				if (scale && !phase_q) begin
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					row_q   <= row_end ? '0 : row_q + HEIGHT_W'(1);
				end
			end else begin
				col_q <= col_q + WIDTH_W'(1);
			end
		end
	end

	`RFCBS_ASSERT_NEXT(a_restart_clears, restart, col_q == '0 && row_q == '0 && !phase_q, "rectangle did not restart after a size or mode write")

endmodule

`default_nettype wire

// ----- sv/rfcbs_queue.sv -----
// ----------------------------------------------------------------------------
// rfcbs_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "raster_fill_copy_blend_scale_assert.svh"

module rfcbs_queue import rfcbs_pkg::*; #(
	parameter int DEPTH = RFCBS_QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t push_entry,
	output logic       full,
	input  wire logic  pop,
	output logic       head_valid,
	output qent_t      head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qent_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`RFCBS_ASSERT_SAME(a_no_overflow, push, !full, "push into a full queue")
	`RFCBS_ASSERT_SAME(a_no_underflow, pop, head_valid, "pop from an empty queue")

endmodule

`default_nettype wire

// ----- sv/rfcbs_back.sv -----
// ----------------------------------------------------------------------------
// rfcbs_back
// Index multiply, alpha blend pipeline and output register with doubling.
// ----------------------------------------------------------------------------
`default_nettype none
`include "raster_fill_copy_blend_scale_assert.svh"

module rfcbs_back import rfcbs_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire qent_t               head,
	output logic                     pop,
	input  wire logic [STRIDE_W-1:0] dest_stride,
	output logic                     wr_valid,
	input  wire logic                wr_stall,
	output wr_t                      wr_data
);

	// Stage 1: products
	logic               valid_s1;
	op_t                op_s1;
	logic [15:0]        pix_s1;
	logic [15:0]        sum_r_s1;
	logic [15:0]        sum_g_s1;
	logic [15:0]        sum_b_s1;
	logic [INDEX_W-1:0] prod_s1;
	logic [DCOL_W-1:0]  dcol_s1;
	logic               last_s1;

	// Stage 2: finished pixel and index
	logic               valid_s2;
	logic               double_s2;
	logic [INDEX_W-1:0] index_s2;
	logic [15:0]        pix_s2;
	logic               last_s2;

	// Output register
	wr_t  out_q;
	logic out_valid_q;
	logic dup_q;
	logic dup_last_q;

	logic [7:0]  alpha;
	logic [7:0]  inv_alpha;
	logic [15:0] sum_r;
	logic [15:0] sum_g;
	logic [15:0] sum_b;
	logic [DROW_W+STRIDE_W-1:0] row_prod;
	logic [7:0]  res_r;
	logic [7:0]  res_g;
	logic [7:0]  res_b;
	logic        take;
	logic        out_load;
	logic        ready_s2;
	logic        ready_s1;

	// Pull back pressure from the output register up the pipe
	assign take     = out_valid_q && !wr_stall;
	assign out_load = valid_s2 && (!out_valid_q || (take && !dup_q));
	assign ready_s2 = !valid_s2 || out_load;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign pop      = head_valid && ready_s1;

	// Weigh source against widened destination per channel
	assign alpha     = head.src[31:24];
	assign inv_alpha = 8'd255 - alpha;
	assign sum_r = 16'(head.src[23:16]) * 16'(alpha) +
		16'({head.dst[15:11], 3'b000}) * 16'(inv_alpha);
	assign sum_g = 16'(head.src[15:8]) * 16'(alpha) +
		16'({head.dst[10:5], 2'b00}) * 16'(inv_alpha);
	assign sum_b = 16'(head.src[7:0]) * 16'(alpha) +
		16'({head.dst[4:0], 3'b000}) * 16'(inv_alpha);
	assign row_prod = (DROW_W+STRIDE_W)'(head.drow) * (DROW_W+STRIDE_W)'(dest_stride);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1    <= head.op;
			pix_s1   <= head.src[15:0];
			sum_r_s1 <= sum_r;
			sum_g_s1 <= sum_g;
			sum_b_s1 <= sum_b;
			prod_s1  <= row_prod[INDEX_W-1:0];
			dcol_s1  <= head.dcol;
			last_s1  <= head.last;
		end
	end

	// Divide by 255 and repack to 565; add the column
	assign res_r = div255(sum_r_s1);
	assign res_g = div255(sum_g_s1);
	assign res_b = div255(sum_b_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			double_s2 <= (op_s1 == OP_DOUBLE);
			index_s2  <= prod_s1 + INDEX_W'(dcol_s1);
			pix_s2    <= (op_s1 == OP_BLEND) ? {res_r[7:3], res_g[7:2], res_b[7:3]} : pix_s1;
			last_s2   <= last_s1;
		end
	end

	// Hold a beat until taken; emit the neighbor column for doubled pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dup_q       <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			dup_q       <= double_s2;
		end else if (take) begin
			out_valid_q <= dup_q;
			dup_q       <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.dest_index <= index_s2;
			out_q.pixel_out  <= pix_s2;
			out_q.last       <= double_s2 ? 1'b0 : last_s2;
			dup_last_q       <= last_s2;
		end else if (take && dup_q) begin
			out_q.dest_index <= out_q.dest_index + INDEX_W'(1);
			out_q.last       <= dup_last_q;
		end
	end

	assign wr_valid = out_valid_q;
	assign wr_data  = out_q;

	`RFCBS_ASSERT_NEXT(a_second_beat, take && dup_q, wr_valid && wr_data.dest_index == $past(wr_data.dest_index) + INDEX_W'(1), "doubled pixel did not follow at the next column")
	`RFCBS_ASSERT_SAME(a_first_not_last, out_valid_q && dup_q, !wr_data.last, "first beat of a doubled pixel marked last")

endmodule

`default_nettype wire

// ----- sv/raster_fill_copy_blend_scale.sv -----
// ----------------------------------------------------------------------------
// raster_fill_copy_blend_scale: RGB565 raster engine, fill/copy/blend/scale
// Path: an accepted pixel beat passes the queue, stage 1, stage 2 and the output register.
// Throughput: 1 item per cycle while wr_stall is low; a scale item takes two write beats.
// Reset: asynchronous, registers to defaults, counters and queue cleared at once.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_fill_copy_blend_scale import rfcbs_pkg::*; #(
	parameter int QUEUE_DEPTH = RFCBS_QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  pix_valid,
	output logic                       pix_stall,
	input  wire pix_t                  pix_data,
	output logic                       wr_valid,
	input  wire logic                  wr_stall,
	output wr_t                        wr_data
);

	logic                push;
	qent_t               push_entry;
	logic                full;
	logic                pop;
	logic                head_valid;
	qent_t               head;
	logic [STRIDE_W-1:0] dest_stride;

	// Classify incoming beats
	rfcbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_data   (pix_data),
		.full       (full),
		.push       (push),
		.push_entry (push_entry),
		.dest_stride(dest_stride)
	);

	// Decouple front and back
	rfcbs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Compute and emit destination writes
	rfcbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.dest_stride(dest_stride),
		.wr_valid   (wr_valid),
		.wr_stall   (wr_stall),
		.wr_data    (wr_data)
	);

endmodule

`default_nettype wire
